/* design/imad_pkg.sv */
// Shared constants and register codes for the IR obstacle moving-average detector.
package imad_pkg;

  localparam int unsigned NumCh = 4;
  localparam int unsigned ChFr  = 0;
  localparam int unsigned ChFl  = 1;
  localparam int unsigned ChBr  = 2;
  localparam int unsigned ChBl  = 3;

  localparam int unsigned GainBits    = 8;
  localparam int unsigned ThreshBits  = 13;
  localparam int unsigned CfgDataBits = 13;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned GainDivisor = 100;

  localparam logic [ThreshBits-1:0] ThreshReset = 13'd850;
  localparam logic [GainBits-1:0]   GainReset   = 8'd110;

  typedef enum logic [CfgIdxBits-1:0] {
    RegDisableAll    = 3'd0,
    RegMaskBackRight = 3'd1,
    RegFrontThresh   = 3'd2,
    RegBackThresh    = 3'd3,
    RegFrontLeftGain = 3'd4
  } cfg_reg_e;

endpackage

/* design/imad_cell.sv */
// One window position: holds one entry per channel and passes it to the older neighbour.
module imad_cell #(
  parameter int unsigned EntryBits = 13
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         shift_i,
  input  logic [imad_pkg::NumCh-1:0][EntryBits-1:0]    entry_i,
  output logic [imad_pkg::NumCh-1:0][EntryBits-1:0]    entry_o
);

  logic [imad_pkg::NumCh-1:0][EntryBits-1:0] entry_q;
  logic [imad_pkg::NumCh-1:0][EntryBits-1:0] entry_d;

  assign entry_d = shift_i ? entry_i : entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

/* design/imad_gain.sv */
// Two-stage front-left gain: sample*gain, then floor(/100) by reciprocal, saturated.
module imad_gain #(
  parameter int unsigned SampleBits = 12
) (
  input  logic                              clk_i,
  input  logic                              en_mul_i,
  input  logic                              en_div_i,
  input  logic [SampleBits-1:0]             sample_i,
  input  logic [imad_pkg::GainBits-1:0]     gain_i,
  output logic [SampleBits:0]               scaled_o
);

  localparam int unsigned EntryBits  = SampleBits + 1;
  localparam int unsigned ProdBits   = SampleBits + imad_pkg::GainBits;
  localparam int unsigned RecipShift = ProdBits + 7;
  localparam int unsigned RecipBits  = RecipShift - 6;
  localparam int unsigned FullBits   = ProdBits + RecipBits;
  localparam int unsigned QuotBits   = ProdBits - 6;
  localparam longint unsigned RecipK =
    ((64'd1 << RecipShift) + 64'(imad_pkg::GainDivisor) - 64'd1) / 64'(imad_pkg::GainDivisor);
  localparam logic [EntryBits-1:0] EntryMax = '1;

  logic [ProdBits-1:0] prod_q;
  logic [ProdBits-1:0] prod_d;
  logic [FullBits-1:0] full;
  logic [QuotBits-1:0] quot_q;
  logic [QuotBits-1:0] quot_d;

  assign prod_d = ProdBits'(sample_i) * ProdBits'(gain_i);
  assign full   = FullBits'(prod_q) * FullBits'(RecipBits'(RecipK));
  assign quot_d = full[FullBits-1:RecipShift];

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      prod_q <= prod_d;
    end
    if (en_div_i) begin
      quot_q <= quot_d;
    end
  end

  assign scaled_o = (quot_q > {1'b0, EntryMax}) ? EntryMax : quot_q[EntryBits-1:0];

endmodule

/* design/ir_obstacle_moving_average_detector.sv */
// Top level: IR obstacle detector with per-channel moving-average windows.
//
//  Channel  | Signals                                        | Direction
//  ---------+------------------------------------------------+----------
//  in       | in_valid_i/in_ready_o, four *_sample_i         | input
//  out      | out_valid_o/out_ready_i, *_detect_o, alarm_led_o | output
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i               | input
//
// One transaction per cycle unless out_ready_i stalls; three register stages (gain
// multiply, reciprocal divide, window shift with running-sum compare) lie between the
// accepting edge and out_valid_o.
// Window state is a row of cells shifted together; running sums are kept per channel.
// Reset clears windows, sums and pipeline valids and loads register defaults.
// Each stage advances when empty or when the next stage advances, so bubbles collapse
// while a result waits on out_ready_i.
module ir_obstacle_moving_average_detector #(
  parameter int unsigned WINDOW_LEN  = 10,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [SAMPLE_BITS-1:0]               front_right_sample_i,
  input  logic [SAMPLE_BITS-1:0]               front_left_sample_i,
  input  logic [SAMPLE_BITS-1:0]               back_right_sample_i,
  input  logic [SAMPLE_BITS-1:0]               back_left_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 front_detect_o,
  output logic                                 back_detect_o,
  output logic                                 alarm_led_o,
  input  logic                                 cfg_we_i,
  input  logic [imad_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [imad_pkg::CfgDataBits-1:0]     cfg_wdata_i
);

  localparam int unsigned EntryBits = SAMPLE_BITS + 1;
  localparam int unsigned SumBits   = EntryBits + $clog2(WINDOW_LEN);
  localparam int unsigned LimBits   = imad_pkg::ThreshBits + $clog2(WINDOW_LEN + 1);
  localparam int unsigned CmpBits   = (SumBits > LimBits) ? SumBits : LimBits;
  localparam int unsigned NumCh     = imad_pkg::NumCh;

  // configuration
  logic                              disable_q;
  logic                              mask_br_q;
  logic [imad_pkg::ThreshBits-1:0]   front_thr_q;
  logic [imad_pkg::ThreshBits-1:0]   back_thr_q;
  logic [imad_pkg::GainBits-1:0]     gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disable_q   <= 1'b0;
      mask_br_q   <= 1'b0;
      front_thr_q <= imad_pkg::ThreshReset;
      back_thr_q  <= imad_pkg::ThreshReset;
      gain_q      <= imad_pkg::GainReset;
    end else if (cfg_we_i) begin
      unique case (imad_pkg::cfg_reg_e'(cfg_idx_i))
        imad_pkg::RegDisableAll:    disable_q   <= cfg_wdata_i[0];
        imad_pkg::RegMaskBackRight: mask_br_q   <= cfg_wdata_i[0];
        imad_pkg::RegFrontThresh:   front_thr_q <= cfg_wdata_i[imad_pkg::ThreshBits-1:0];
        imad_pkg::RegBackThresh:    back_thr_q  <= cfg_wdata_i[imad_pkg::ThreshBits-1:0];
        imad_pkg::RegFrontLeftGain: gain_q      <= cfg_wdata_i[imad_pkg::GainBits-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1_q, v2_q, ov_q;
  logic rdy1, rdy2, rdy3;
  logic fire_in, fire2, fire3;
  logic dis1_q, dis2_q;

  assign rdy3    = !ov_q || out_ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign fire_in = in_valid_i && rdy1;
  assign fire2   = v1_q && rdy2;
  assign fire3   = v2_q && rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        ov_q <= v2_q;
      end
    end
  end

  // payload stages
  logic [SAMPLE_BITS-1:0] fr1_q, br1_q, bl1_q;
  logic [SAMPLE_BITS-1:0] fr2_q, br2_q, bl2_q;
  logic [EntryBits-1:0]   fl_scaled;

  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      fr1_q  <= front_right_sample_i;
      br1_q  <= back_right_sample_i;
      bl1_q  <= back_left_sample_i;
      dis1_q <= disable_q;
    end
    if (fire2) begin
      fr2_q  <= fr1_q;
      br2_q  <= br1_q;
      bl2_q  <= bl1_q;
      dis2_q <= dis1_q;
    end
  end

  imad_gain #(
    .SampleBits(SAMPLE_BITS)
  ) u_gain (
    .clk_i    (clk_i),
    .en_mul_i (fire_in),
    .en_div_i (fire2),
    .sample_i (front_left_sample_i),
    .gain_i   (gain_q),
    .scaled_o (fl_scaled)
  );

  // window cells
  logic                                 shift;
  logic [NumCh-1:0][EntryBits-1:0]      chain [WINDOW_LEN+1];

  assign shift = fire3 && !dis2_q;

  assign chain[WINDOW_LEN][imad_pkg::ChFr] = {1'b0, fr2_q};
  assign chain[WINDOW_LEN][imad_pkg::ChFl] = fl_scaled;
  assign chain[WINDOW_LEN][imad_pkg::ChBr] = {1'b0, br2_q};
  assign chain[WINDOW_LEN][imad_pkg::ChBl] = {1'b0, bl2_q};

  for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
    imad_cell #(
      .EntryBits(EntryBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (chain[g+1]),
      .entry_o (chain[g])
    );
  end

  // running sums and compare
  logic [NumCh-1:0][SumBits-1:0] sum_q, sum_d;
  logic [NumCh-1:0]              over;
  logic [CmpBits-1:0]            front_lim, back_lim;
  logic                          front, back;

  assign front_lim = CmpBits'(front_thr_q) * CmpBits'(WINDOW_LEN);
  assign back_lim  = CmpBits'(back_thr_q) * CmpBits'(WINDOW_LEN);

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      sum_d[c] = sum_q[c] + SumBits'(chain[WINDOW_LEN][c]) - SumBits'(chain[0][c]);
    end
  end

  assign over[imad_pkg::ChFr] = CmpBits'(sum_d[imad_pkg::ChFr]) > front_lim;
  assign over[imad_pkg::ChFl] = CmpBits'(sum_d[imad_pkg::ChFl]) > front_lim;
  assign over[imad_pkg::ChBr] = CmpBits'(sum_d[imad_pkg::ChBr]) > back_lim;
  assign over[imad_pkg::ChBl] = CmpBits'(sum_d[imad_pkg::ChBl]) > back_lim;

  assign front = !dis2_q && (over[imad_pkg::ChFr] || over[imad_pkg::ChFl]);
  assign back  = !dis2_q && (over[imad_pkg::ChBl] || (!mask_br_q && over[imad_pkg::ChBr]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (shift) begin
      sum_q <= sum_d;
    end
  end

  logic front_q, back_q, alarm_q;

  always_ff @(posedge clk_i) begin
    if (fire3) begin
      front_q <= front;
      back_q  <= back;
      alarm_q <= front || back;
    end
  end

  assign in_ready_o     = rdy1;
  assign out_valid_o    = ov_q;
  assign front_detect_o = front_q;
  assign back_detect_o  = back_q;
  assign alarm_led_o    = alarm_q;

endmodule
